// File: design/spac_pkg.sv
// Package with shared types, constants and helpers of the speaker protection audio chain.
`timescale 1ns / 1ps
`default_nettype none

package spac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_BLUETOOTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS_POLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_COEFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOUDNESS_BOOST  = 3'd4;

    localparam logic [14:0] RST_HIGHPASS_POLE  = 15'd28816;
    localparam logic [14:0] RST_LOWPASS_COEFF  = 15'd3530;
    localparam logic [14:0] RST_VOLUME_GAIN    = 15'd13045;
    localparam logic [14:0] RST_LOUDNESS_BOOST = 15'd7545;

    localparam logic signed [17:0] SMOOTH_ALPHA = 18'sd148;
    localparam logic signed [17:0] LIM_SLOPE    = 18'sd18619;
    localparam logic signed [17:0] LIM_ATTACK   = 18'sd1453;
    localparam logic signed [17:0] LIM_RELEASE  = 18'sd32753;
    localparam logic signed [32:0] LIM_THRESH_S = 33'sd27000;
    localparam logic [16:0]        LIM_THRESH   = 17'd27000;
    localparam logic [16:0]        LIM_FLOOR    = 17'd24576;
    localparam logic [16:0]        UNITY_Q15    = 17'd32768;

    localparam logic signed [36:0] INT32_MAX_W = 37'sd2147483647;
    localparam logic signed [36:0] INT32_MIN_W = -37'sd2147483648;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HP,
        OP_BOOST,
        OP_LP,
        OP_GAIN,
        OP_SHELF,
        OP_VOL,
        OP_ENV,
        OP_SLOPE,
        OP_LGAIN,
        OP_LIM,
        OP_BT
    } op_t;

    typedef struct packed {
        logic accept;
        op_t  launch;
        op_t  consume;
    } cmd_t;

    typedef struct packed {
        logic route_bluetooth;
    } status_t;

    function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
        logic signed [15:0] r;
        if (v > 37'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -37'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/spac_datapath.sv
// Datapath of the audio chain: configuration, filter history, shared multiplier and output.
`timescale 1ns / 1ps
`default_nettype none

module spac_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spac_pkg::cmd_t                    cmd,
    output spac_pkg::status_t                      status,
    input  wire logic signed [15:0]                sample_in,
    input  wire logic                              channel,
    input  wire logic                              restart,
    output logic signed [15:0]                     sample_out,
    input  wire logic                              cfg_write_en,
    input  wire logic [spac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic              route_reg;
    logic [14:0]       pole_reg;
    logic [14:0]       lpc_reg;
    logic [14:0]       vol_reg;
    logic [14:0]       boost_reg;

    logic signed [15:0] hpi_reg [2];
    logic signed [31:0] hpo_reg [2];
    logic signed [15:0] shelf_reg [2];
    logic signed [15:0] bs_reg;
    logic signed [15:0] gs_reg;
    logic [16:0]        env_reg;
    logic [16:0]        lg_reg;

    logic signed [15:0] x_reg;
    logic               ch_reg;
    logic signed [15:0] y_reg;
    logic [16:0]        tg_reg;
    logic signed [50:0] prod_reg;
    logic signed [15:0] out_reg;

    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [35:0] pq;

    logic signed [16:0] bs_diff;
    logic signed [16:0] gs_diff;
    logic signed [16:0] lp_diff;
    logic signed [17:0] tl_diff;
    logic signed [36:0] hp_sum;
    logic signed [31:0] hp_sat;
    logic signed [17:0] shelf_sum;
    logic signed [16:0] y_ext;
    logic [16:0]        abs_y;
    logic [16:0]        tg_raw;
    logic [16:0]        tg_calc;

    assign status.route_bluetooth = route_reg;
    assign sample_out = out_reg;

    assign bs_diff = signed'({2'b00, boost_reg}) - 17'(bs_reg);
    assign gs_diff = signed'({2'b00, vol_reg}) - 17'(gs_reg);
    assign lp_diff = 17'(y_reg) - 17'(shelf_reg[ch_reg]);
    assign tl_diff = signed'({1'b0, tg_reg}) - signed'({1'b0, lg_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.launch)
            spac_pkg::OP_HP:
            begin
                mul_a = 33'(hpo_reg[ch_reg]);
                mul_b = signed'({3'b000, pole_reg});
            end
            spac_pkg::OP_BOOST:
            begin
                mul_a = 33'(bs_diff);
                mul_b = spac_pkg::SMOOTH_ALPHA;
            end
            spac_pkg::OP_LP:
            begin
                mul_a = 33'(lp_diff);
                mul_b = signed'({3'b000, lpc_reg});
            end
            spac_pkg::OP_GAIN:
            begin
                mul_a = 33'(gs_diff);
                mul_b = spac_pkg::SMOOTH_ALPHA;
            end
            spac_pkg::OP_SHELF:
            begin
                mul_a = 33'(shelf_reg[ch_reg]);
                mul_b = 18'(bs_reg);
            end
            spac_pkg::OP_VOL:
            begin
                mul_a = 33'(y_reg);
                mul_b = 18'(gs_reg);
            end
            spac_pkg::OP_ENV:
            begin
                mul_a = signed'({16'b0, env_reg});
                mul_b = spac_pkg::LIM_RELEASE;
            end
            spac_pkg::OP_SLOPE:
            begin
                mul_a = signed'({16'b0, env_reg}) - spac_pkg::LIM_THRESH_S;
                mul_b = spac_pkg::LIM_SLOPE;
            end
            spac_pkg::OP_LGAIN:
            begin
                mul_a = 33'(tl_diff);
                mul_b = tl_diff[17] ? spac_pkg::LIM_ATTACK : spac_pkg::LIM_RELEASE;
            end
            spac_pkg::OP_LIM:
            begin
                mul_a = 33'(y_reg);
                mul_b = signed'({1'b0, lg_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign pq = prod_reg[50:15];

    always_comb
    begin
        hp_sum = 37'(x_reg) - 37'(hpi_reg[ch_reg]) + 37'(pq);
        if (hp_sum > spac_pkg::INT32_MAX_W)
        begin
            hp_sat = 32'sh7FFFFFFF;
        end
        else if (hp_sum < spac_pkg::INT32_MIN_W)
        begin
            hp_sat = 32'sh80000000;
        end
        else
        begin
            hp_sat = hp_sum[31:0];
        end
        shelf_sum = 18'(y_reg) + 18'(pq);
        y_ext = 17'(y_reg);
        abs_y = y_ext[16] ? 17'(-y_ext) : y_ext;
        tg_raw = spac_pkg::UNITY_Q15 - 17'(pq);
        if (env_reg > spac_pkg::LIM_THRESH)
        begin
            tg_calc = (tg_raw < spac_pkg::LIM_FLOOR) ? spac_pkg::LIM_FLOOR : tg_raw;
        end
        else
        begin
            tg_calc = spac_pkg::UNITY_Q15;
        end
    end

    // Configuration and filter history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_reg    <= 1'b0;
            pole_reg     <= spac_pkg::RST_HIGHPASS_POLE;
            lpc_reg      <= spac_pkg::RST_LOWPASS_COEFF;
            vol_reg      <= spac_pkg::RST_VOLUME_GAIN;
            boost_reg    <= spac_pkg::RST_LOUDNESS_BOOST;
            hpi_reg[0]   <= '0;
            hpi_reg[1]   <= '0;
            hpo_reg[0]   <= '0;
            hpo_reg[1]   <= '0;
            shelf_reg[0] <= '0;
            shelf_reg[1] <= '0;
            bs_reg       <= signed'({1'b0, spac_pkg::RST_LOUDNESS_BOOST});
            gs_reg       <= signed'({1'b0, spac_pkg::RST_VOLUME_GAIN});
            env_reg      <= '0;
            lg_reg       <= spac_pkg::UNITY_Q15;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    spac_pkg::CFG_ROUTE_BLUETOOTH: route_reg <= cfg_data[0];
                    spac_pkg::CFG_HIGHPASS_POLE:   pole_reg  <= cfg_data;
                    spac_pkg::CFG_LOWPASS_COEFF:   lpc_reg   <= cfg_data;
                    spac_pkg::CFG_VOLUME_GAIN:     vol_reg   <= cfg_data;
                    spac_pkg::CFG_LOUDNESS_BOOST:  boost_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accept && restart)
            begin
                hpi_reg[0]   <= '0;
                hpi_reg[1]   <= '0;
                hpo_reg[0]   <= '0;
                hpo_reg[1]   <= '0;
                shelf_reg[0] <= '0;
                shelf_reg[1] <= '0;
                env_reg      <= '0;
                lg_reg       <= spac_pkg::UNITY_Q15;
                gs_reg       <= signed'({1'b0, vol_reg});
            end
            case (cmd.consume)
                spac_pkg::OP_HP:
                begin
                    hpi_reg[ch_reg] <= x_reg;
                    hpo_reg[ch_reg] <= hp_sat;
                end
                spac_pkg::OP_BOOST: bs_reg <= bs_reg + 16'(pq);
                spac_pkg::OP_LP:    shelf_reg[ch_reg] <= shelf_reg[ch_reg] + 16'(pq);
                spac_pkg::OP_GAIN:  gs_reg <= gs_reg + 16'(pq);
                spac_pkg::OP_ENV:   env_reg <= (abs_y > env_reg) ? abs_y : 17'(pq);
                spac_pkg::OP_LGAIN: lg_reg <= lg_reg + 17'(pq);
                default:
                begin
                end
            endcase
        end
    end

    // Working values of the beat in flight.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg  <= sample_in;
            ch_reg <= channel;
            y_reg  <= sample_in;
        end
        if (cmd.launch != spac_pkg::OP_NONE)
        begin
            prod_reg <= mul_p;
        end
        case (cmd.consume)
            spac_pkg::OP_HP:    y_reg   <= spac_pkg::sat16(37'(hp_sat));
            spac_pkg::OP_SHELF: y_reg   <= spac_pkg::sat16(37'(shelf_sum));
            spac_pkg::OP_VOL:   y_reg   <= 16'(pq);
            spac_pkg::OP_SLOPE: tg_reg  <= tg_calc;
            spac_pkg::OP_LIM:   out_reg <= spac_pkg::sat16(37'(pq));
            spac_pkg::OP_BT:    out_reg <= 16'(pq);
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/spac_controller.sv
// Sequencing state machine of the audio chain and output valid tracking.
`timescale 1ns / 1ps
`default_nettype none

module spac_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire spac_pkg::status_t status,
    output spac_pkg::cmd_t         cmd
);

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_HP_L  = 20'h00002,
        ST_HP_C  = 20'h00004,
        ST_BS_C  = 20'h00008,
        ST_LP_C  = 20'h00010,
        ST_GS_C  = 20'h00020,
        ST_SH_C  = 20'h00040,
        ST_VOL_L = 20'h00080,
        ST_VOL_C = 20'h00100,
        ST_ENV_C = 20'h00200,
        ST_SL_L  = 20'h00400,
        ST_SL_C  = 20'h00800,
        ST_LG_L  = 20'h01000,
        ST_LG_C  = 20'h02000,
        ST_LIM_L = 20'h04000,
        ST_LIM_C = 20'h08000,
        ST_BT_L  = 20'h10000,
        ST_BT_C  = 20'h20000,
        ST_BT_VL = 20'h40000,
        ST_BT_VC = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   blocked;
    logic   finish;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign blocked   = out_valid_reg && out_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.launch  = spac_pkg::OP_NONE;
        cmd.consume = spac_pkg::OP_NONE;
        finish      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.route_bluetooth ? ST_BT_L : ST_HP_L;
                end
            end
            ST_HP_L:
            begin
                cmd.launch = spac_pkg::OP_HP;
                state_next = ST_HP_C;
            end
            ST_HP_C:
            begin
                cmd.consume = spac_pkg::OP_HP;
                cmd.launch  = spac_pkg::OP_BOOST;
                state_next  = ST_BS_C;
            end
            ST_BS_C:
            begin
                cmd.consume = spac_pkg::OP_BOOST;
                cmd.launch  = spac_pkg::OP_LP;
                state_next  = ST_LP_C;
            end
            ST_LP_C:
            begin
                cmd.consume = spac_pkg::OP_LP;
                cmd.launch  = spac_pkg::OP_GAIN;
                state_next  = ST_GS_C;
            end
            ST_GS_C:
            begin
                cmd.consume = spac_pkg::OP_GAIN;
                cmd.launch  = spac_pkg::OP_SHELF;
                state_next  = ST_SH_C;
            end
            ST_SH_C:
            begin
                cmd.consume = spac_pkg::OP_SHELF;
                state_next  = ST_VOL_L;
            end
            ST_VOL_L:
            begin
                cmd.launch = spac_pkg::OP_VOL;
                state_next = ST_VOL_C;
            end
            ST_VOL_C:
            begin
                cmd.consume = spac_pkg::OP_VOL;
                cmd.launch  = spac_pkg::OP_ENV;
                state_next  = ST_ENV_C;
            end
            ST_ENV_C:
            begin
                cmd.consume = spac_pkg::OP_ENV;
                state_next  = ST_SL_L;
            end
            ST_SL_L:
            begin
                cmd.launch = spac_pkg::OP_SLOPE;
                state_next = ST_SL_C;
            end
            ST_SL_C:
            begin
                cmd.consume = spac_pkg::OP_SLOPE;
                state_next  = ST_LG_L;
            end
            ST_LG_L:
            begin
                cmd.launch = spac_pkg::OP_LGAIN;
                state_next = ST_LG_C;
            end
            ST_LG_C:
            begin
                cmd.consume = spac_pkg::OP_LGAIN;
                state_next  = ST_LIM_L;
            end
            ST_LIM_L:
            begin
                cmd.launch = spac_pkg::OP_LIM;
                state_next = ST_LIM_C;
            end
            ST_LIM_C:
            begin
                if (!blocked)
                begin
                    cmd.consume = spac_pkg::OP_LIM;
                    finish      = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_BT_L:
            begin
                cmd.launch = spac_pkg::OP_GAIN;
                state_next = ST_BT_C;
            end
            ST_BT_C:
            begin
                cmd.consume = spac_pkg::OP_GAIN;
                state_next  = ST_BT_VL;
            end
            ST_BT_VL:
            begin
                cmd.launch = spac_pkg::OP_VOL;
                state_next = ST_BT_VC;
            end
            ST_BT_VC:
            begin
                if (!blocked)
                begin
                    cmd.consume = spac_pkg::OP_BT;
                    finish      = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/speaker_protection_audio_chain_top.sv
// Top level of the speaker protection audio chain.
// One beat carries one signed 16-bit sample with its channel and restart flag and yields one
// processed sample. In the speaker route a beat passes from the acceptance cycle through fifteen
// controller steps that run ten dependent products through one shared, registered 33 x 18
// multiplier. The Bluetooth route runs a shorter sequence of two products. A new beat
// is accepted once the controller is back in idle, while the previous result may still wait in
// the output register; processing then holds in its last step until that result is taken.
// Configuration writes are taken at any time but are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module speaker_protection_audio_chain_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [15:0]                sample_in,
    input  wire logic                              channel,
    input  wire logic                              restart,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [15:0]                     sample_out,
    input  wire logic                              cfg_write_en,
    input  wire logic [spac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    spac_pkg::cmd_t    cmd;
    spac_pkg::status_t status;

    spac_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    spac_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_in    (sample_in),
        .channel      (channel),
        .restart      (restart),
        .sample_out   (sample_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

`default_nettype wire

// File: design/spac_checker.sv
// Port-level checks of the audio chain and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spac_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [15:0] sample_out
);

    // Only one beat is in work at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a beat is in work");

    // No route produces a result in the cycle right after acceptance.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

    // A new result only appears at the end of a busy period.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a beat in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("stalled output beat changed");

endmodule

bind speaker_protection_audio_chain_top spac_checker u_spac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);

`default_nettype wire
